@@ rtl/bollinger_band_filter_macros.svh @@
// Assertion macros used by the checker module of the band filter.
`ifndef BOLLINGER_BAND_FILTER_MACROS_SVH
`define BOLLINGER_BAND_FILTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bbf_pkg.sv @@
package bbf_pkg;

    // Field widths fixed by the interface.
    localparam int PRICE_W   = 32;
    localparam int BAND_W    = 40;
    localparam int WLEN_W    = 7;
    localparam int MULT_W    = 12;
    localparam int CFG_W     = 12;
    localparam int SQRT_W    = 64;
    localparam int SD_W      = 32;
    localparam int OFF_W     = MULT_W + SD_W - 8;

    // Default window store depth.
    localparam int WINDOW_MAX_DEF = 64;

    // Register reset values.
    localparam logic [WLEN_W-1:0] WLEN_RST = 7'd20;
    localparam logic [MULT_W-1:0] MULT_RST = 12'd512;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_BAND_MULT     = 1'b1
    } cfg_idx_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic var_start;
        logic div_start;
        logic div_var;
        logic sqrt_start;
        logic mul;
        logic load_out;
    } bbf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic walk_done;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } bbf_sts_t;

endpackage

@@ rtl/bbf_ctrl.sv @@
module bbf_ctrl
    import bbf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  bbf_sts_t sts,
    output bbf_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SUM  = 8'b0000_0010,
        ST_DIVM = 8'b0000_0100,
        ST_VAR  = 8'b0000_1000,
        ST_DIVV = 8'b0001_0000,
        ST_SQRT = 8'b0010_0000,
        ST_MUL  = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencing of the per-item phases.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.full ? ST_SUM : ST_FIN;
                end
            end
            ST_SUM:
            begin
                if (sts.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVM;
                end
            end
            ST_DIVM:
            begin
                if (sts.div_done)
                begin
                    cmd.var_start = 1'b1;
                    state_next    = ST_VAR;
                end
            end
            ST_VAR:
            begin
                if (sts.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_var   = 1'b1;
                    state_next    = ST_DIVV;
                end
            end
            ST_DIVV:
            begin
                if (sts.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/bbf_datapath.sv @@
module bbf_datapath
    import bbf_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [PRICE_W-1:0]   price,
    input  logic                 restart,
    input  bbf_cmd_t             cmd,
    output bbf_sts_t             sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 bands_valid,
    output logic [PRICE_W-1:0]   middle,
    output logic [BAND_W-1:0]    upper,
    output logic [BAND_W-1:0]    lower
);

    localparam int PTRW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNTW = $clog2(WINDOW_MAX + 1);
    localparam int SUMW = PRICE_W + PTRW;
    localparam int ACCW = 2 * PRICE_W + PTRW;
    localparam int DCNTW = $clog2(ACCW + 1);
    localparam int SCNTW = $clog2(SQRT_W / 2 + 1);
    localparam logic [PTRW-1:0] PTR_LAST = PTRW'(WINDOW_MAX - 1);

    // Configuration registers.
    logic [WLEN_W-1:0] wlen_reg;
    logic [MULT_W-1:0] mult_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_RST;
            mult_reg <= MULT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_LENGTH: wlen_reg <= cfg_data[WLEN_W-1:0];
                CFG_BAND_MULT:     mult_reg <= cfg_data[MULT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective window length, clamped to one up to the store depth.
    logic [31:0]     wlen_ext;
    logic [CNTW-1:0] len_eff;

    assign wlen_ext = 32'(wlen_reg);
    assign len_eff  = (wlen_ext == 32'd0) ? CNTW'(1) :
                      (wlen_ext > 32'(WINDOW_MAX)) ? CNTW'(WINDOW_MAX) : CNTW'(wlen_ext);

    // Write pointer and fill count for the incoming item.
    logic [PTRW-1:0] wp_reg;
    logic [CNTW-1:0] fill_reg;
    logic [PTRW-1:0] wp_base;
    logic [CNTW-1:0] fill_base;
    logic [CNTW-1:0] fill_new;

    assign wp_base   = restart ? '0 : wp_reg;
    assign fill_base = restart ? '0 : fill_reg;
    assign fill_new  = (fill_base < CNTW'(WINDOW_MAX)) ? fill_base + CNTW'(1) : fill_base;
    assign sts.full  = (fill_new >= len_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (cmd.accept)
        begin
            wp_reg   <= (wp_base == PTR_LAST) ? '0 : wp_base + PTRW'(1);
            fill_reg <= fill_new;
        end
    end

    // Window store: one write port, one registered read port.
    logic [PRICE_W-1:0] mem [WINDOW_MAX];
    logic [PTRW-1:0]    rd_ptr_reg;
    logic [PRICE_W-1:0] rd_q;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mem[wp_base] <= price;
        end
        rd_q <= mem[rd_ptr_reg];
    end

    // Walk over the window, newest entry first.
    logic [PTRW-1:0] newest_reg;
    logic [CNTW-1:0] len_reg;
    logic            full_reg;
    logic [CNTW-1:0] walk_cnt_reg;
    logic            walk_var_reg;
    logic            v1_reg;
    logic            v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_cnt_reg <= '0;
            walk_var_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            full_reg     <= 1'b0;
            len_reg      <= '0;
            newest_reg   <= '0;
            rd_ptr_reg   <= '0;
        end
        else
        begin
            v1_reg <= (walk_cnt_reg != '0);
            v2_reg <= v1_reg && walk_var_reg;
            if (cmd.accept)
            begin
                len_reg      <= len_eff;
                full_reg     <= sts.full;
                newest_reg   <= wp_base;
                rd_ptr_reg   <= wp_base;
                walk_var_reg <= 1'b0;
                walk_cnt_reg <= sts.full ? len_eff : '0;
            end
            else if (cmd.var_start)
            begin
                rd_ptr_reg   <= newest_reg;
                walk_var_reg <= 1'b1;
                walk_cnt_reg <= len_reg;
            end
            else if (walk_cnt_reg != '0)
            begin
                rd_ptr_reg   <= (rd_ptr_reg == '0) ? PTR_LAST : rd_ptr_reg - PTRW'(1);
                walk_cnt_reg <= walk_cnt_reg - CNTW'(1);
            end
        end
    end

    assign sts.walk_done = (walk_cnt_reg == '0) && !v1_reg && !v2_reg;

    // Sum and sum of squared deviations.
    logic [SUMW-1:0]      sum_reg;
    logic [ACCW-1:0]      acc_reg;
    logic [2*PRICE_W-1:0] sq_reg;
    logic [PRICE_W-1:0]   mid_reg;
    logic [PRICE_W-1:0]   dev;

    assign dev = (rd_q >= mid_reg) ? rd_q - mid_reg : mid_reg - rd_q;

    always_ff @(posedge clk)
    begin
        sq_reg <= dev * dev;
        if (cmd.accept)
        begin
            sum_reg <= '0;
        end
        else if (v1_reg && !walk_var_reg)
        begin
            sum_reg <= sum_reg + SUMW'(rd_q);
        end
        if (cmd.var_start)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACCW'(sq_reg);
        end
    end

    // Restoring divider by the window length, one quotient bit a cycle.
    logic [ACCW-1:0]  dvd_reg;
    logic [CNTW-1:0]  rem_reg;
    logic [DCNTW-1:0] dcnt_reg;
    logic [CNTW:0]    rem_try;
    logic             qbit;

    assign rem_try = {rem_reg, dvd_reg[ACCW-1]};
    assign qbit    = (rem_try >= {1'b0, len_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= DCNTW'(ACCW);
        end
        else if (dcnt_reg != '0)
        begin
            dcnt_reg <= dcnt_reg - DCNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg <= cmd.div_var ? acc_reg : ACCW'(sum_reg);
            rem_reg <= '0;
        end
        else if (dcnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[ACCW-2:0], qbit};
            rem_reg <= qbit ? CNTW'(rem_try - {1'b0, len_reg}) : CNTW'(rem_try);
        end
        if (cmd.var_start)
        begin
            mid_reg <= dvd_reg[PRICE_W-1:0];
        end
    end

    assign sts.div_done = (dcnt_reg == '0);

    // Bit-pair square root of the variance, one result bit a cycle.
    logic [SQRT_W-1:0] sv_reg;
    logic [SQRT_W-1:0] sres_reg;
    logic [SQRT_W-1:0] sbit_reg;
    logic [SCNTW-1:0]  scnt_reg;
    logic [SQRT_W:0]   strial;

    assign strial = {1'b0, sres_reg} + {1'b0, sbit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scnt_reg <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            scnt_reg <= SCNTW'(SQRT_W / 2);
        end
        else if (scnt_reg != '0)
        begin
            scnt_reg <= scnt_reg - SCNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sv_reg   <= dvd_reg[SQRT_W-1:0];
            sres_reg <= '0;
            sbit_reg <= SQRT_W'(1) << (SQRT_W - 2);
        end
        else if (scnt_reg != '0)
        begin
            if ({1'b0, sv_reg} >= strial)
            begin
                sv_reg   <= sv_reg - strial[SQRT_W-1:0];
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
    end

    assign sts.sqrt_done = (scnt_reg == '0);

    // Band offset from the scaled standard deviation.
    logic [OFF_W-1:0]        off_reg;
    logic [MULT_W+SD_W-1:0]  prod;

    assign prod = mult_reg * sres_reg[SD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            off_reg <= prod[MULT_W+SD_W-1:8];
        end
    end

    // Output register.
    assign sts.out_free = !m_tvalid || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            bands_valid <= full_reg;
            if (full_reg)
            begin
                middle <= mid_reg;
                upper  <= BAND_W'(mid_reg) + BAND_W'(off_reg);
                lower  <= BAND_W'(mid_reg) - BAND_W'(off_reg);
            end
            else
            begin
                middle <= '0;
                upper  <= '0;
                lower  <= '0;
            end
        end
    end

endmodule

@@ rtl/bollinger_band_filter.sv @@
// When the window is not yet full, an accepted item goes straight to the
// output register; otherwise the block makes two walks of the window store,
// two passes of the bit-serial divider and a 32-step square root before the
// result is loaded. One item is in work at a time; the next is taken in the
// cycle after the result is loaded into the output register. Reset (rst_n,
// asynchronous, active low) empties the window and restores length 20 and
// multiplier 2.0.
module bollinger_band_filter
    import bbf_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PRICE_W-1:0]   s_tdata,   // price
    input  logic                 s_tuser,   // restart
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [111:0]         m_tdata,   // middle, upper, lower
    output logic                 m_tuser    // bands_valid
);

    bbf_cmd_t           cmd;
    bbf_sts_t           sts;
    logic [PRICE_W-1:0] middle;
    logic [BAND_W-1:0]  upper;
    logic [BAND_W-1:0]  lower;

    assign m_tdata = {lower, upper, middle};

    bbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bbf_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .price       (s_tdata),
        .restart     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .bands_valid (m_tuser),
        .middle      (middle),
        .upper       (upper),
        .lower       (lower)
    );

endmodule

@@ rtl/bbf_checker.sv @@
`include "bollinger_band_filter_macros.svh"

module bbf_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic         m_tuser
);

    // A result waiting to be taken stays offered.
    `BBF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // One item at a time: the block is busy right after taking an item.
    `BBF_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "item taken while busy")

    // An incomplete window reports all-zero bands.
    `BBF_ASSERT_NOW(a_zero, m_tvalid && !m_tuser, m_tdata == 112'd0, "bands not zero")

    // The bands are symmetric about the middle.
    `BBF_ASSERT_NOW(a_sym, m_tvalid && m_tuser,
        40'(m_tdata[71:32] + m_tdata[111:72]) == 40'({m_tdata[31:0], 1'b0}),
        "bands not symmetric")

endmodule

bind bollinger_band_filter bbf_checker u_bbf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
